/* hw/rtl/scm_pkg.sv */
// shared types and constants for the sample-clocked metronome
package scm_pkg;

    // fixed-point format of samples per beat and phase
    localparam int FRAC_BITS   = 8;
    localparam int PHASE_W     = 32;
    localparam int COUNT_BITS  = 48;
    localparam int BEAT_W      = 4;
    localparam int BPB_W       = 5;
    localparam int BAR_W       = 32;
    localparam int FRACT_OUT_W = 16;
    localparam int DIST_W      = 29;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int QUANT_W     = 2;

    // divider sizing: dividend is phase shifted up by the output fraction width
    localparam int DIV_STEPS   = PHASE_W + FRACT_OUT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // product of beats left and samples per beat
    localparam int PROD_W      = PHASE_W + BPB_W;
    localparam int DIFF_W      = PROD_W + 2;

    localparam logic [PHASE_W-1:0] ONE_SAMPLE  = PHASE_W'(1) << FRAC_BITS;
    localparam logic [PHASE_W-1:0] SPB_RESET   = PHASE_W'(24000) << FRAC_BITS;
    localparam logic [BPB_W-1:0]   BPB_RESET   = BPB_W'(4);
    localparam logic [BPB_W-1:0]   BPB_MIN     = BPB_W'(1);
    localparam logic [BPB_W-1:0]   BPB_MAX     = BPB_W'(16);
    localparam logic [DIST_W-1:0]  DIST_MAX    = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPB = 2'd0,
        CFG_BPB = 2'd1,
        CFG_RUN = 2'd2
    } t_cfg_reg;

    // quantize codes
    typedef enum logic [QUANT_W-1:0] {
        Q_FREE = 2'd0,
        Q_BEAT = 2'd1,
        Q_BAR  = 2'd2
    } t_quant;

    // input kind codes
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic [PHASE_W-1:0] spb;
        logic [BPB_W-1:0]   bpb;
        logic               running;
    } t_config;

    typedef struct packed {
        logic                  beat_event;
        logic                  bar_event;
        logic [BEAT_W-1:0]     beat;
        logic [BAR_W-1:0]      bar;
        logic [COUNT_BITS-1:0] samples;
        logic [PHASE_W-1:0]    phase;
    } t_status;

endpackage

/* hw/rtl/scm_position.sv */
// configuration registers and beat/bar position state
module scm_position (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr,
    input  logic [scm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_step,
    input  logic                            i_kind,
    output scm_pkg::t_config                o_cfg,
    output scm_pkg::t_status                o_status
);
    import scm_pkg::*;

    t_config r_cfg, n_cfg;
    t_status r_st, n_st;

    logic [PHASE_W:0]   ph_sum;
    logic [PHASE_W:0]   ph_wrap;
    logic [BPB_W-1:0]   beat_inc;
    logic [BPB_W-1:0]   bpb_sat;

    // saturated beats-per-bar write value
    always_comb begin
        bpb_sat = i_cfg_data[BPB_W-1:0];
        if (bpb_sat < BPB_MIN) begin
            bpb_sat = BPB_MIN;
        end else if (bpb_sat > BPB_MAX) begin
            bpb_sat = BPB_MAX;
        end
    end

    // phase advance by one sample, wrapped once at samples per beat
    assign ph_sum   = {1'b0, r_st.phase} + {1'b0, ONE_SAMPLE};
    assign ph_wrap  = ph_sum - {1'b0, r_cfg.spb};
    assign beat_inc = {1'b0, r_st.beat} + BPB_W'(1);

    // next config and position
    always_comb begin
        n_cfg = r_cfg;
        n_st  = r_st;
        if (i_cfg_wr) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SPB: begin
                    n_cfg.spb = (i_cfg_data < ONE_SAMPLE) ? ONE_SAMPLE : i_cfg_data;
                end
                CFG_BPB: begin
                    n_cfg.bpb = bpb_sat;
                    if ({1'b0, r_st.beat} >= bpb_sat) begin
                        n_st.beat = '0;
                        n_st.bar  = r_st.bar + BAR_W'(1);
                    end
                end
                CFG_RUN: begin
                    n_cfg.running = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
        if (i_step) begin
            n_st.beat_event = 1'b0;
            n_st.bar_event  = 1'b0;
            if (i_kind == KIND_CLEAR) begin
                n_st.phase   = '0;
                n_st.beat    = '0;
                n_st.bar     = '0;
                n_st.samples = '0;
            end else if (r_cfg.running) begin
                n_st.samples = r_st.samples + COUNT_BITS'(1);
                n_st.phase   = ph_sum[PHASE_W-1:0];
                if (ph_sum >= {1'b0, r_cfg.spb}) begin
                    n_st.phase      = ph_wrap[PHASE_W-1:0];
                    n_st.beat_event = 1'b1;
                    if (beat_inc >= r_cfg.bpb) begin
                        n_st.beat      = '0;
                        n_st.bar       = r_st.bar + BAR_W'(1);
                        n_st.bar_event = 1'b1;
                    end else begin
                        n_st.beat = beat_inc[BEAT_W-1:0];
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spb     <= SPB_RESET;
            r_cfg.bpb     <= BPB_RESET;
            r_cfg.running <= 1'b0;
            r_st          <= '0;
        end else begin
            r_cfg <= n_cfg;
            r_st  <= n_st;
        end
    end

    assign o_cfg    = r_cfg;
    assign o_status = r_st;

endmodule

/* hw/rtl/scm_divider.sv */
// restoring divider, one quotient bit per cycle, keeps low quotient bits
module scm_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [scm_pkg::PHASE_W-1:0]       i_num,
    input  logic [scm_pkg::PHASE_W-1:0]       i_den,
    output logic                              o_busy,
    output logic [scm_pkg::FRACT_OUT_W-1:0]   o_quo
);
    import scm_pkg::*;

    logic                   r_busy;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DIV_STEPS-1:0]   r_num;
    logic [PHASE_W-1:0]     r_den;
    logic [PHASE_W:0]       r_rem;
    logic [FRACT_OUT_W-1:0] r_quo;

    logic [PHASE_W:0]       trial;
    logic [PHASE_W:0]       diff;
    logic                   ge;

    // one trial subtraction per cycle
    assign trial = {r_rem[PHASE_W-1:0], r_num[DIV_STEPS-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_num, {FRACT_OUT_W{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_STEPS-2:0], 1'b0};
            r_rem <= ge ? diff : trial;
            r_quo <= {r_quo[FRACT_OUT_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

/* hw/rtl/sample_clocked_metronome.sv */
// Sample-clocked metronome top level: sequencer, distance logic and output register.
// Each accepted item is one audio sample tick or a position clear. The position
// (beat, bar, sample count, phase) is updated at the accept edge; the item then
// passes a preparation state and a divide state that runs the restoring divider
// forming the UQ0.16 beat fraction one bit a cycle. The result is registered as
// the sequencer returns to idle, and no new item is taken before then. o_stall is
// high whenever the sequencer is not idle. The result sits in an
// output register until taken; if it is still held when the next result is done,
// the sequencer waits. Configuration writes are always ready and are meant to be
// made while the block is idle.
module sample_clocked_metronome (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_kind,
    input  logic [scm_pkg::QUANT_W-1:0]       i_quantize,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_beat_event,
    output logic                              o_bar_event,
    output logic [scm_pkg::BEAT_W-1:0]        o_beat,
    output logic [scm_pkg::BAR_W-1:0]         o_bar,
    output logic [scm_pkg::COUNT_BITS-1:0]    o_total_samples,
    output logic [scm_pkg::FRACT_OUT_W-1:0]   o_beat_fraction,
    output logic [scm_pkg::DIST_W-1:0]        o_samples_to_boundary,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import scm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PREP = 3'b010,
        S_DIV  = 3'b100
    } t_state;

    t_state r_state, n_state;

    t_config cfg;
    t_status st;

    logic                   in_acc;
    logic                   out_free;
    logic                   finish;
    logic                   div_start;
    logic                   div_busy;
    logic [FRACT_OUT_W-1:0] div_quo;

    logic [QUANT_W-1:0]     r_quant;
    logic [PROD_W-1:0]      r_prod;
    logic [BPB_W-1:0]       left;
    logic [BPB_W-1:0]       beats_left;
    logic [PROD_W-1:0]      prod;
    logic [DIFF_W-1:0]      dist_sum;
    logic [DIFF_W-FRAC_BITS-1:0] dist_whole;
    logic [DIST_W-1:0]      dist_sat;

    logic                   r_out_valid;
    logic                   r_out_beat_ev;
    logic                   r_out_bar_ev;
    logic [BEAT_W-1:0]      r_out_beat;
    logic [BAR_W-1:0]       r_out_bar;
    logic [COUNT_BITS-1:0]  r_out_samples;
    logic [FRACT_OUT_W-1:0] r_out_fract;
    logic [DIST_W-1:0]      r_out_dist;

    assign in_acc      = i_valid && (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_stall;
    assign div_start   = (r_state == S_PREP);
    assign finish      = (r_state == S_DIV) && !div_busy && out_free;

    scm_position u_position (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (in_acc),
        .i_kind      (i_kind),
        .o_cfg       (cfg),
        .o_status    (st)
    );

    scm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (st.phase),
        .i_den   (cfg.spb),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // beats left to the asked boundary, one for the next beat
    assign beats_left = (cfg.bpb > {1'b0, st.beat}) ? (cfg.bpb - {1'b0, st.beat})
                                                    : BPB_W'(1);
    assign left = (t_quant'(r_quant) == Q_BAR) ? beats_left : BPB_W'(1);
    assign prod = PROD_W'(left) * PROD_W'(cfg.spb);

    // capture quantize code and the boundary product
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_quant <= i_quantize;
        end
        if (r_state == S_PREP) begin
            r_prod <= prod;
        end
    end

    // distance rounded half up; a negative value past half a sample saturates
    assign dist_sum   = DIFF_W'(r_prod) + DIFF_W'(ONE_SAMPLE >> 1) - DIFF_W'(st.phase);
    assign dist_whole = dist_sum[DIFF_W-1:FRAC_BITS];

    always_comb begin
        dist_sat = '0;
        case (t_quant'(r_quant))
            Q_BEAT, Q_BAR: begin
                if (dist_sum[DIFF_W-1] || (dist_whole > (DIFF_W-FRAC_BITS)'(DIST_MAX))) begin
                    dist_sat = DIST_MAX;
                end else begin
                    dist_sat = dist_whole[DIST_W-1:0];
                end
            end
            default: begin
                dist_sat = '0;
            end
        endcase
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_beat_ev <= st.beat_event;
            r_out_bar_ev  <= st.bar_event;
            r_out_beat    <= st.beat;
            r_out_bar     <= st.bar;
            r_out_samples <= st.samples;
            r_out_fract   <= div_quo;
            r_out_dist    <= dist_sat;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_beat_event          = r_out_beat_ev;
    assign o_bar_event           = r_out_bar_ev;
    assign o_beat                = r_out_beat;
    assign o_bar                 = r_out_bar;
    assign o_total_samples       = r_out_samples;
    assign o_beat_fraction       = r_out_fract;
    assign o_samples_to_boundary = r_out_dist;

endmodule
